// File: hdl/iirdf_pkg.sv
// Shared types and constants of the direct form I IIR filter.
package iirdf_pkg;

    localparam int DATA_W   = 32;
    localparam int COEF_W   = 48;
    localparam int NUM_FEED = 4;
    localparam int NUM_BACK = 3;
    localparam int NUM_REGS = 8;
    localparam int ACC_W    = 84;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [2:0]               t_cfg_idx;
    typedef logic [2:0]               t_num_terms;

    localparam t_cfg_idx REG_NUM_TERMS = 3'd0;
    localparam t_cfg_idx REG_FEED_0    = 3'd1;
    localparam t_cfg_idx REG_FEED_1    = 3'd2;
    localparam t_cfg_idx REG_FEED_2    = 3'd3;
    localparam t_cfg_idx REG_FEED_3    = 3'd4;
    localparam t_cfg_idx REG_BACK_0    = 3'd5;
    localparam t_cfg_idx REG_BACK_1    = 3'd6;
    localparam t_cfg_idx REG_BACK_2    = 3'd7;

    localparam t_sample SAT_MAX = 32'sh7FFF_FFFF;
    localparam t_sample SAT_MIN = 32'sh8000_0000;

    // One multiply request travelling down the arithmetic pipe.
    typedef struct packed {
        logic       valid;
        logic [1:0] term;
        logic       is_back;
        logic       is_high;
    } t_op_tag;

endpackage

// File: hdl/iirdf_sample_if.sv
// Request channel carrying one raw sensor sample.
interface iirdf_sample_if;
    import iirdf_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// File: hdl/iirdf_result_if.sv
// Request channel carrying one filtered value and its saturation flag.
interface iirdf_result_if;
    import iirdf_pkg::*;

    logic    valid;
    logic    ready;
    t_sample filtered;
    logic    saturated;

    modport source (output valid, output filtered, output saturated, input ready);
    modport sink (input valid, input filtered, input saturated, output ready);
endinterface

// File: hdl/iir_direct_form_filter.sv
// Direct form I IIR filter with ring histories held in two small synchronous memories.
// Each request takes a low-half and a high-half multiplier pass per feedforward tap and per
// active feedback tap; identity mode skips the multiplier and hands the sample straight on.
// One request at a time goes through the single shared 33 x 32 bit multiplier, so the next
// request is taken only once the last result has been registered for output.
// Reset (synchronous, active low) clears the configuration, the history valid bits,
// the write slot and all handshake state; history entries not yet written read as zero.
module iir_direct_form_filter #(
    parameter int MAX_TAPS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  iirdf_pkg::t_cfg_idx  i_cfg_idx,
    input  iirdf_pkg::t_coef     i_cfg_data,
    iirdf_sample_if.sink         i_smp,
    iirdf_result_if.source       o_res
);
    import iirdf_pkg::*;

    localparam int SW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TW = SW + 2;
    localparam logic [2:0] TAP_CLAMP = (MAX_TAPS > 7) ? 3'd7 : 3'(MAX_TAPS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_TAPS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // Configuration registers.
    t_num_terms r_num_terms;
    t_coef      r_feed [NUM_FEED];
    t_coef      r_back [NUM_BACK];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_terms <= '0;
            for (int k = 0; k < NUM_FEED; k++) r_feed[k] <= '0;
            for (int k = 0; k < NUM_BACK; k++) r_back[k] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NUM_TERMS: r_num_terms <= i_cfg_data[2:0];
                REG_FEED_0:    r_feed[0] <= i_cfg_data;
                REG_FEED_1:    r_feed[1] <= i_cfg_data;
                REG_FEED_2:    r_feed[2] <= i_cfg_data;
                REG_FEED_3:    r_feed[3] <= i_cfg_data;
                REG_BACK_0:    r_back[0] <= i_cfg_data;
                REG_BACK_1:    r_back[1] <= i_cfg_data;
                REG_BACK_2:    r_back[2] <= i_cfg_data;
                default:       r_num_terms <= r_num_terms;
            endcase
        end
    end

    // Control state.
    logic [1:0]    r_state;
    logic [SW-1:0] r_slot;
    logic [MAX_TAPS-1:0] r_valid;
    logic          r_ident;
    logic [2:0]    r_ntaps;
    logic          r_issuing;
    logic [1:0]    r_term;
    logic [1:0]    r_last_term;
    logic [1:0]    r_sub;
    logic [SW-1:0] r_addr;
    t_op_tag       r_tag1;
    t_op_tag       r_tag2;
    logic          r_out_valid;

    // Payload registers.
    t_sample                   r_sample;
    t_sample                   r_xq;
    t_sample                   r_yq;
    logic                      r_vq;
    logic signed [64:0]        r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    t_sample                   r_out_data;
    logic                      r_out_sat;

    // Ring histories: one write and one registered read per cycle each.
    t_sample mem_x [MAX_TAPS];
    t_sample mem_y [MAX_TAPS];

    logic w_accept;
    logic w_fin_go;
    assign i_smp.ready = (r_state == ST_IDLE);
    assign w_accept    = i_smp.valid && i_smp.ready;
    assign w_fin_go    = (r_state == ST_FIN) && (!r_out_valid || o_res.ready);

    // Window set-up at acceptance: the window ends at the slot being written.
    logic [2:0]    w_ntaps;
    logic [TW-1:0] w_start_raw;
    logic [SW-1:0] w_start;
    logic [1:0]    w_last_term;
    always_comb begin
        w_ntaps     = (r_num_terms > TAP_CLAMP) ? TAP_CLAMP : r_num_terms;
        w_start_raw = TW'(r_slot) + TW'(MAX_TAPS + 1) - TW'(w_ntaps);
        if (w_start_raw >= TW'(MAX_TAPS)) begin
            w_start_raw = w_start_raw - TW'(MAX_TAPS);
        end
        w_start     = w_start_raw[SW-1:0];
        // Only the four oldest taps of the window carry a feedforward coefficient.
        w_last_term = (w_ntaps > 3'(NUM_FEED)) ? 2'(NUM_FEED - 1) : 2'(w_ntaps - 3'd1);
    end

    // The newest output tap never contributes, nor does any tap past the third.
    logic w_back_en;
    assign w_back_en = ((3'(r_term) + 3'd1) < r_ntaps) && (r_term < 2'(NUM_BACK));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_valid     <= '0;
            r_ident     <= 1'b0;
            r_ntaps     <= '0;
            r_issuing   <= 1'b0;
            r_term      <= '0;
            r_last_term <= '0;
            r_sub       <= '0;
            r_addr      <= '0;
            r_tag1      <= '0;
            r_tag2      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_RUN && r_issuing) begin
                r_tag1 <= '{valid: 1'b1, term: r_term,
                            is_back: r_sub[1], is_high: r_sub[0]};
            end else begin
                r_tag1 <= '0;
            end
            r_tag2 <= r_tag1;

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_ident     <= (r_num_terms == '0);
                        r_ntaps     <= w_ntaps;
                        r_last_term <= w_last_term;
                        r_addr      <= w_start;
                        r_term      <= '0;
                        r_sub       <= '0;
                        if (r_num_terms == '0) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_valid[r_slot] <= 1'b1;
                            r_issuing       <= 1'b1;
                            r_state         <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (r_issuing) begin
                        if (r_sub == 2'd0 || r_sub == 2'd2) begin
                            r_sub <= r_sub + 2'd1;
                        end else if (r_sub == 2'd1 && w_back_en) begin
                            r_sub <= 2'd2;
                        end else begin
                            r_sub  <= 2'd0;
                            r_term <= r_term + 2'd1;
                            r_addr <= (r_addr == LAST_SLOT) ? '0 : r_addr + SW'(1);
                            if (r_term == r_last_term) begin
                                r_issuing <= 1'b0;
                            end
                        end
                    end else if (!r_tag1.valid && !r_tag2.valid) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_fin_go) begin
                        r_state     <= ST_IDLE;
                        if (!r_ident) begin
                            r_slot <= (r_slot == LAST_SLOT) ? '0 : r_slot + SW'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Rounding of the Q52.32 sum to nearest, ties upward, then clipping to 32 bits.
    logic signed [ACC_W-1:0] w_round;
    logic [ACC_W-33:0]       w_quot;
    logic                    w_sat;
    t_sample                 w_result;
    always_comb begin
        w_round = r_acc + ACC_W'(64'sd2147483648);
        w_quot  = w_round[ACC_W-1:32];
        w_sat   = !((&w_quot[ACC_W-33:31]) || !(|w_quot[ACC_W-33:31]));
        if (r_ident) begin
            w_result = r_sample;
        end else if (w_sat) begin
            w_result = w_quot[ACC_W-33] ? SAT_MIN : SAT_MAX;
        end else begin
            w_result = t_sample'(w_quot[31:0]);
        end
    end

    // Multiply stage: coefficient halves are the unsigned low 32 bits and the
    // signed high 16 bits, so each coefficient takes two passes through the multiplier.
    t_coef              w_coef;
    logic signed [32:0] w_cpart;
    t_sample            w_val;
    always_comb begin
        w_coef  = r_tag1.is_back ? r_back[r_tag1.term] : r_feed[r_tag1.term];
        w_cpart = r_tag1.is_high ? 33'($signed(w_coef[COEF_W-1:32]))
                                 : $signed({1'b0, w_coef[31:0]});
        w_val   = !r_vq ? '0 : (r_tag1.is_back ? r_yq : r_xq);
    end

    logic signed [ACC_W-1:0] w_term;
    assign w_term = r_tag2.is_high ? $signed({r_prod[ACC_W-33:0], 32'b0})
                                   : ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_smp.sample;
            r_acc    <= '0;
            if (r_num_terms != '0) begin
                mem_x[r_slot] <= i_smp.sample;
            end
        end else if (r_tag2.valid) begin
            // Feedback terms are subtracted, which spares negating the output.
            r_acc <= r_tag2.is_back ? r_acc - w_term : r_acc + w_term;
        end
        if (w_fin_go && !r_ident) begin
            mem_y[r_slot] <= w_result;
        end
        if (w_fin_go) begin
            r_out_data <= w_result;
            r_out_sat  <= w_sat && !r_ident;
        end
        r_xq   <= mem_x[r_addr];
        r_yq   <= mem_y[r_addr];
        r_vq   <= r_valid[r_addr];
        r_prod <= w_cpart * w_val;
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.filtered  = r_out_data;
    assign o_res.saturated = r_out_sat;

endmodule

// File: hdl/iirdf_checker.sv
// Port-level assertions of the IIR filter and their binding to the top level.
module iirdf_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input iirdf_pkg::t_sample i_filtered,
    input logic              i_saturated
);
    import iirdf_pkg::*;

    // A held result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_filtered)
            && $stable(i_saturated))
        else $error("result changed while stalled");

    // Only one request is in flight at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while one is in flight");

    // A clipped result sits at one of the two limits.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |-> i_filtered == SAT_MAX || i_filtered == SAT_MIN)
        else $error("saturated result not at a limit");

endmodule

bind iir_direct_form_filter iirdf_checker u_iirdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_filtered  (o_res.filtered),
    .i_saturated (o_res.saturated)
);

// File: bench/iir_direct_form_filter_tb.sv
// Self-checking testbench of the direct form I IIR filter: directed table, then random phases.
module iir_direct_form_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iirdf_pkg::*;

    localparam int MAX_TAPS = 4;

    // Cycles to let pass once the last expected result is in, covering the longest latency.
    localparam int DRAIN_CYCLES   = 25;
    // The receiver's one long hold-off, to fill the block and stall its input.
    localparam int HOLD_CYCLES    = 400;
    // Cycles without any accepted request before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 650;

    localparam t_coef COEF_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam t_coef COEF_MIN = 48'sh8000_0000_0000;
    localparam t_coef UNITY    = 48'sh0001_0000_0000;
    localparam t_coef HALF     = 48'sh0000_8000_0000;

    typedef struct packed {
        t_sample filtered;
        logic    saturated;
    } t_filt_res;

    // A directed row either writes a register, or offers a sample whose result is typed in,
    // or offers a sample whose result comes from the predictor.
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_TYPED,
        ROW_PREDICT
    } t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_cfg_idx  idx;
        t_coef     data;
        t_sample   sample;
        t_filt_res typed_res;
    } t_dir_row;

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    t_cfg_idx cfg_idx;
    t_coef    cfg_data;

    iirdf_sample_if smp_if ();
    iirdf_result_if res_if ();

    iir_direct_form_filter #(
        .MAX_TAPS(MAX_TAPS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_smp      (smp_if.sink),
        .o_res      (res_if.source)
    );

    // The predictor's own copy of the configuration and of the two ring histories.
    t_num_terms cfg_terms;
    t_coef      cfg_feed [NUM_FEED];
    t_coef      cfg_back [NUM_BACK];
    t_sample    hist_x   [MAX_TAPS];
    t_sample    hist_y   [MAX_TAPS];
    int         hist_slot;

    // Results still owed by the block, oldest first.
    t_filt_res  filtered_q [$];
    t_dir_row   dir_rows [$];

    int fail_count;
    int quiet_cycles;
    bit sent_since_cfg;
    bit hold_wanted;
    bit hold_done;

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Mostly back-to-back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mirrors one register write into the predictor's configuration.
    function automatic void apply_register(t_cfg_idx idx, t_coef data);
        case (idx)
            REG_NUM_TERMS: cfg_terms   = data[2:0];
            REG_FEED_0:    cfg_feed[0] = data;
            REG_FEED_1:    cfg_feed[1] = data;
            REG_FEED_2:    cfg_feed[2] = data;
            REG_FEED_3:    cfg_feed[3] = data;
            REG_BACK_0:    cfg_back[0] = data;
            REG_BACK_1:    cfg_back[1] = data;
            REG_BACK_2:    cfg_back[2] = data;
            default: ;
        endcase
    endfunction

    // Works out the filter output for one accepted sample and advances the histories.
    // The sum is kept exactly at 96 bits, which holds seven 80-bit products with room to
    // spare. Rounding adds one half and floors, so ties go towards plus infinity.
    function automatic t_filt_res filter_sample(t_sample x);
        t_filt_res        r;
        logic signed [95:0] acc;
        logic signed [95:0] coef_w;
        logic signed [95:0] val_w;
        logic signed [95:0] rounded;
        logic signed [95:0] top;
        logic signed [95:0] bottom;
        int taps;
        int first;
        int idx;
        int n;
        acc = '0;
        top = SAT_MAX;
        bottom = SAT_MIN;
        if (cfg_terms == 0) begin
            // Identity: the sample passes straight through and the histories stay put.
            r.filtered = x;
            r.saturated = 1'b0;
            return r;
        end
        taps = (cfg_terms > MAX_TAPS) ? MAX_TAPS : int'(cfg_terms);
        hist_x[hist_slot] = x;
        hist_y[hist_slot] = '0;
        first = hist_slot + MAX_TAPS + 1 - taps;
        for (n = 0; n < taps; n++) begin
            idx = (first + n) % MAX_TAPS;
            if (n < NUM_FEED) begin
                coef_w = cfg_feed[n];
                val_w = hist_x[idx];
                acc = acc + coef_w * val_w;
            end
            // The newest feedback tap never contributes.
            if (n + 1 < taps && n < NUM_BACK) begin
                coef_w = cfg_back[n];
                val_w = hist_y[idx];
                acc = acc - coef_w * val_w;
            end
        end
        rounded = (acc + 96'sh8000_0000) >>> 32;
        r.saturated = 1'b0;
        if (rounded > top) begin
            rounded = top;
            r.saturated = 1'b1;
        end else if (rounded < bottom) begin
            rounded = bottom;
            r.saturated = 1'b1;
        end
        r.filtered = rounded[31:0];
        // The clipped value is what goes into the output history.
        hist_y[hist_slot] = r.filtered;
        hist_slot = (hist_slot + 1) % MAX_TAPS;
        return r;
    endfunction

    // Draws a coefficient: extremes, zero, values near unity, or anything at all. Feedback
    // coefficients are kept gentle so that most settings stay stable.
    function automatic t_coef draw_coef(bit gentle);
        logic [63:0] w;
        int pick;
        w = {$urandom(), $urandom()};
        pick = $urandom_range(0, 19);
        case (pick)
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            default: ;
        endcase
        if (gentle) return t_coef'($signed(w[30:0]));
        if (pick < 14) return t_coef'($signed(w[33:0]));
        return w[47:0];
    endfunction

    function automatic void add_write(t_cfg_idx idx, t_coef data);
        t_dir_row row;
        row.kind = ROW_WRITE;
        row.idx = idx;
        row.data = data;
        row.sample = '0;
        row.typed_res = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_typed(t_sample sample, t_sample filtered, logic saturated);
        t_dir_row row;
        row.kind = ROW_TYPED;
        row.idx = REG_NUM_TERMS;
        row.data = '0;
        row.sample = sample;
        row.typed_res.filtered = filtered;
        row.typed_res.saturated = saturated;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_predict(t_sample sample);
        t_dir_row row;
        row.kind = ROW_PREDICT;
        row.idx = REG_NUM_TERMS;
        row.data = '0;
        row.sample = sample;
        row.typed_res = '0;
        dir_rows.push_back(row);
    endfunction

    // Registers may only change while the block is idle. Once samples have gone in, the
    // sender drops its request, every owed result is collected, and the pipe is given time
    // to empty before the first write.
    task automatic settle();
        if (sent_since_cfg) begin
            smp_if.valid <= 1'b0;
            while (filtered_q.size() != 0) @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
            sent_since_cfg = 1'b0;
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, t_coef data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        apply_register(idx, data);
    endtask

    // Offers one sample and holds it until the block takes the request. The expectation is
    // queued at the edge of acceptance, either typed in or from the predictor, which runs
    // in both cases so that its histories follow the block.
    task automatic offer_sample(t_sample value, bit typed, t_filt_res typed_res);
        t_filt_res predicted;
        int gap;
        if (cfg_we) cfg_we <= 1'b0;
        smp_if.valid <= 1'b1;
        smp_if.sample <= value;
        do @(posedge clk); while (!smp_if.ready);
        predicted = filter_sample(value);
        filtered_q.push_back(typed ? typed_res : predicted);
        sent_since_cfg = 1'b1;
        gap = pick_gap();
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Every accepted result is compared with the oldest expectation.
    always @(posedge clk) begin
        t_filt_res want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (filtered_q.size() == 0) begin
                $error("result with nothing expected: filtered %0d saturated %0b",
                       res_if.filtered, res_if.saturated);
                fail_count++;
            end else begin
                want = filtered_q.pop_front();
                if (res_if.filtered !== want.filtered) begin
                    $error("filtered: expected %0d, actual %0d", want.filtered, res_if.filtered);
                    fail_count++;
                end
                if (res_if.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, actual %0b",
                           want.saturated, res_if.saturated);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run if neither channel moves a request for too long.
    always @(posedge clk) begin
        if (!rst_n || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: runs of readiness broken by pauses, plus one long hold-off on request from
    // the sender, so that the block fills up while samples keep being offered.
    initial begin
        int stretch;
        int gap;
        res_if.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_wanted && !hold_done) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            res_if.ready <= 1'b1;
            stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 8);
            repeat (stretch) @(posedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial begin
        int         random_sent;
        int         phase;
        int         count;
        int         k;
        int         r;
        logic [63:0] w;
        t_num_terms terms;
        t_coef      coef;
        t_sample    value;

        fail_count = 0;
        sent_since_cfg = 1'b0;
        hold_wanted = 1'b0;
        hold_done = 1'b0;
        cfg_terms = '0;
        hist_slot = 0;
        for (k = 0; k < NUM_FEED; k++) cfg_feed[k] = '0;
        for (k = 0; k < NUM_BACK; k++) cfg_back[k] = '0;
        for (k = 0; k < MAX_TAPS; k++) begin
            hist_x[k] = '0;
            hist_y[k] = '0;
        end

        smp_if.valid <= 1'b0;
        smp_if.sample <= '0;
        cfg_we <= 1'b0;
        cfg_idx <= REG_NUM_TERMS;
        cfg_data <= '0;
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Straight after reset the block is in identity mode.
        add_typed(32'sh0000_0000, 32'sh0000_0000, 1'b0);
        add_typed(SAT_MAX, SAT_MAX, 1'b0);
        add_typed(SAT_MIN, SAT_MIN, 1'b0);
        add_typed(-32'sd1, -32'sd1, 1'b0);
        // One tap at unity gain passes both extremes unchanged.
        add_write(REG_NUM_TERMS, 48'd1);
        add_write(REG_FEED_0, UNITY);
        add_typed(SAT_MAX, SAT_MAX, 1'b0);
        add_typed(SAT_MIN, SAT_MIN, 1'b0);
        // Half gain puts odd samples exactly on a tie, which rounds upwards.
        add_write(REG_FEED_0, HALF);
        add_typed(32'sd1, 32'sd1, 1'b0);
        add_typed(-32'sd1, 32'sd0, 1'b0);
        add_typed(32'sd3, 32'sd2, 1'b0);
        add_typed(-32'sd3, -32'sd1, 1'b0);
        // Extreme gains clip in both directions.
        add_write(REG_FEED_0, COEF_MAX);
        add_typed(SAT_MAX, SAT_MAX, 1'b1);
        add_typed(SAT_MIN, SAT_MIN, 1'b1);
        add_write(REG_FEED_0, COEF_MIN);
        add_typed(SAT_MIN, SAT_MAX, 1'b1);
        add_typed(SAT_MAX, SAT_MIN, 1'b1);
        add_typed(32'sd0, 32'sd0, 1'b0);
        // Full filter with every register set, the last feedback one at its extreme.
        add_write(REG_NUM_TERMS, 48'd4);
        add_write(REG_FEED_0, UNITY);
        add_write(REG_FEED_1, -HALF);
        add_write(REG_FEED_2, 48'sh0000_4000_0000);
        add_write(REG_FEED_3, 48'sh0002_0000_0000);
        add_write(REG_BACK_0, 48'sh0000_4000_0000);
        add_write(REG_BACK_1, -HALF);
        add_write(REG_BACK_2, COEF_MAX);
        add_predict(32'sd1000);
        add_predict(-32'sd77777);
        add_predict(SAT_MAX);
        add_predict(32'sd5);
        // Identity in mid stream leaves the histories as they were.
        add_write(REG_NUM_TERMS, 48'd0);
        add_typed(32'sd12345, 32'sd12345, 1'b0);
        // More taps than the block has are taken as the full count.
        add_write(REG_NUM_TERMS, 48'd7);
        add_predict(-32'sd424242);
        add_predict(SAT_MIN);
        // Two taps: the one active feedback tap sees the stored, clipped output.
        add_write(REG_NUM_TERMS, 48'd2);
        add_write(REG_BACK_0, HALF);
        add_predict(32'sd999);
        add_predict(-32'sd31);
        add_write(REG_NUM_TERMS, 48'd3);
        add_predict(32'sd65536);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_WRITE: begin
                    settle();
                    write_reg(dir_rows[i].idx, dir_rows[i].data);
                end
                ROW_TYPED:   offer_sample(dir_rows[i].sample, 1'b1, dir_rows[i].typed_res);
                ROW_PREDICT: offer_sample(dir_rows[i].sample, 1'b0, '0);
                default: ;
            endcase
        end

        // Random phases, each with a fresh setting of every register. The first two
        // put every coefficient at one extreme or the other.
        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            settle();
            r = $urandom_range(0, 9);
            if (phase == 0) terms = 3'd4;
            else if (phase == 1) terms = 3'd7;
            else if (r == 0) terms = 3'd0;
            else if (r < 8) terms = t_num_terms'($urandom_range(1, 4));
            else terms = t_num_terms'($urandom_range(5, 7));
            // Upper bits of the word are junk that the tap count must ignore.
            w = {$urandom(), $urandom()};
            write_reg(REG_NUM_TERMS, {w[47:3], terms});
            for (k = 0; k < NUM_FEED; k++) begin
                coef = (phase == 0) ? COEF_MAX : (phase == 1) ? COEF_MIN : draw_coef(1'b0);
                write_reg(t_cfg_idx'(REG_FEED_0 + k), coef);
            end
            for (k = 0; k < NUM_BACK; k++) begin
                coef = (phase == 0) ? COEF_MAX : (phase == 1) ? COEF_MIN : draw_coef(1'b1);
                write_reg(t_cfg_idx'(REG_BACK_0 + k), coef);
            end
            count = $urandom_range(20, 70);
            for (k = 0; k < count; k++) begin
                // Partway into the third phase the receiver is asked to hold off.
                if (phase == 2 && k == 10) hold_wanted = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    case ($urandom_range(0, 4))
                        0: value = SAT_MAX;
                        1: value = SAT_MIN;
                        2: value = '0;
                        3: value = -32'sd1;
                        default: value = 32'sd1;
                    endcase
                end else if (r < 65) begin
                    value = $urandom();
                end else begin
                    value = int'($urandom_range(0, 2000)) - 1000;
                end
                offer_sample(value, 1'b0, '0);
            end
            random_sent += count;
            phase++;
        end

        if (cfg_we) cfg_we <= 1'b0;
        smp_if.valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (filtered_q.size() != 0) begin
            $error("%0d results never arrived", filtered_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
